FILE: rtl/core/url_percent_decoder_defines.svh
// Assertion macros shared by the URL percent decoder RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URL_PD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("url_percent_decoder: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define URL_PD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("url_percent_decoder: assertion failed");

`endif

FILE: rtl/core/url_pd_pkg.sv
// Shared types, constants and helpers for the URL percent decoder.
// No dependencies; used by the front end, the queue, the back end and the top level.
`default_nettype none

package url_pd_pkg;

    localparam logic [7:0] PERCENT_CHAR = 8'h25;
    localparam logic [4:0] HEX_INVALID  = 5'd16;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // One queued work unit: up to three output bytes, emitted data[0] first.
    // The last flag belongs to the final byte of the unit.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] data;
        logic            last;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Returns 0..15 for a hex digit of either case, HEX_INVALID otherwise.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        case (c) inside
            [8'h30:8'h39]: v = 5'(c - 8'h30);
            [8'h41:8'h46]: v = 5'(c - 8'h41 + 8'd10);
            [8'h61:8'h66]: v = 5'(c - 8'h61 + 8'd10);
            default:       v = HEX_INVALID;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/url_pd_stream_if.sv
// Valid/ready stream interfaces for the input and output beats of the decoder.
// No dependencies; used by the front end, the back end and the top level.
`default_nettype none

interface url_pd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface url_pd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/url_pd_front.sv
// Front end: accepts input beats, tracks the escape state and builds output commands.
// Depends on url_pd_pkg and url_pd_in_if.
`default_nettype none

module url_pd_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    url_pd_in_if.sink         i_in,
    input  wire               i_full,
    output url_pd_pkg::t_q_wr o_wr
);

    url_pd_pkg::t_phase r_phase;
    url_pd_pkg::t_phase n_phase;
    logic [7:0]         r_held;
    logic [7:0]         n_held;

    logic               accept;
    logic [4:0]         lo_val;
    logic [4:0]         hi_val;
    logic               is_hex;
    logic               pct_plain;
    url_pd_pkg::t_cmd   cmd;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    assign lo_val    = url_pd_pkg::hex_value(i_in.in_byte);
    assign hi_val    = url_pd_pkg::hex_value(r_held);
    assign is_hex    = !lo_val[4];
    // A percent sign that does not end the string opens a new escape.
    assign pct_plain = (i_in.in_byte == url_pd_pkg::PERCENT_CHAR) && !i_in.in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= url_pd_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
        r_held <= n_held;
    end

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        cmd      = '0;
        cmd.last = i_in.in_last;
        case (r_phase)
            url_pd_pkg::PH_PCT: begin
                if (is_hex && !i_in.in_last) begin
                    n_held  = i_in.in_byte;
                    n_phase = url_pd_pkg::PH_DIGIT;
                end else begin
                    cmd.data[0] = url_pd_pkg::PERCENT_CHAR;
                    cmd.data[1] = i_in.in_byte;
                    cmd.count   = pct_plain ? 2'd1 : 2'd2;
                    n_phase     = pct_plain ? url_pd_pkg::PH_PCT : url_pd_pkg::PH_IDLE;
                end
            end
            url_pd_pkg::PH_DIGIT: begin
                if (is_hex) begin
                    cmd.data[0] = {(hi_val[4] ? 4'd0 : hi_val[3:0]), lo_val[3:0]};
                    cmd.count   = 2'd1;
                    n_phase     = url_pd_pkg::PH_IDLE;
                end else begin
                    cmd.data[0] = url_pd_pkg::PERCENT_CHAR;
                    cmd.data[1] = r_held;
                    cmd.data[2] = i_in.in_byte;
                    cmd.count   = pct_plain ? 2'd2 : 2'd3;
                    n_phase     = pct_plain ? url_pd_pkg::PH_PCT : url_pd_pkg::PH_IDLE;
                end
            end
            default: begin
                // Idle, and the unused phase code, which behaves as idle.
                cmd.data[0] = i_in.in_byte;
                cmd.count   = pct_plain ? 2'd0 : 2'd1;
                n_phase     = pct_plain ? url_pd_pkg::PH_PCT : url_pd_pkg::PH_IDLE;
            end
        endcase
        if (!accept) begin
            n_phase = r_phase;
            n_held  = r_held;
        end
    end

    assign o_wr.push = accept && (cmd.count != 2'd0);
    assign o_wr.cmd  = cmd;

endmodule

`default_nettype wire

FILE: rtl/core/url_pd_queue.sv
// Small flop-based FIFO of output commands between the front and back ends.
// Depends on url_pd_pkg.
`default_nettype none

module url_pd_queue #(
    parameter int DEPTH = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  url_pd_pkg::t_q_wr   i_wr,
    input  wire                 i_pop,
    output logic                o_full,
    output url_pd_pkg::t_q_head o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    url_pd_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr.push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/url_pd_back.sv
// Back end: walks the bytes of the queued command and drives the output register.
// Depends on url_pd_pkg, url_pd_out_if and the assertion macros header.
`default_nettype none
`include "url_percent_decoder_defines.svh"

module url_pd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  url_pd_pkg::t_q_head i_head,
    output logic                o_pop,
    url_pd_out_if.source        o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic       load;
    logic       final_byte;
    logic [7:0] sel_byte;

    // The output register is a full stage, so the head advances whenever it is
    // empty or its beat is being taken.
    assign load       = i_head.valid && (!r_valid || o_out.ready);
    assign final_byte = (r_idx == (i_head.cmd.count - 2'd1));
    assign o_pop      = load && final_byte;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.cmd.data[0];
            2'd1:    sel_byte = i_head.cmd.data[1];
            2'd2:    sel_byte = i_head.cmd.data[2];
            default: sel_byte = i_head.cmd.data[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= final_byte ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
        if (load) begin
            r_byte <= sel_byte;
            r_last <= i_head.cmd.last && final_byte;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;

    `URL_PD_ASSERT_NOW(a_head_nonempty, i_clk, i_rst_n, i_head.valid, i_head.cmd.count != 2'd0)
    `URL_PD_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, i_head.valid, r_idx < i_head.cmd.count)
    `URL_PD_ASSERT_NEXT(a_idx_holds_on_stall, i_clk, i_rst_n, r_valid && !o_out.ready, $stable(r_idx))
    `URL_PD_ASSERT_NOW(a_idx_zero_when_empty, i_clk, i_rst_n, !i_head.valid, r_idx == 2'd0)

endmodule

`default_nettype wire

FILE: rtl/core/url_percent_decoder.sv
// URL percent decoder: one encoded byte per input beat, decoded bytes out.
// An accepted input beat's command is registered in the command queue, and its bytes
// then pass through the back end's output register. Throughput: one output beat per
// cycle while the output is ready; an input beat that flushes k bytes gives k output
// beats; the input takes one beat per cycle while the QUEUE_DEPTH-entry queue has room.
// Reset (synchronous, active low) clears the escape state, the queue and the output valid.
`default_nettype none

module url_percent_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    url_pd_in_if.sink    i_in,
    url_pd_out_if.source o_out
);

    url_pd_pkg::t_q_wr   wr;
    url_pd_pkg::t_q_head head;
    logic                q_full;
    logic                pop;

    url_pd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_wr    (wr)
    );

    url_pd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    url_pd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
